// ===== sv/msts_pkg.sv =====
// ----------------------------------------------------------------------------
// msts_pkg: shared definitions for the multi-slot timer scheduler
// Table size, field widths, action and status codes, and the layout of one
// timer entry as it is kept in the timer RAM.
// ----------------------------------------------------------------------------
package msts_pkg;

  // Number of timer slots in the table.
  localparam int SLOTS = 16;
  // Address width of the timer table and width of the walk counter.
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 31;
  localparam int ELAPSED_W = 20;
  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 3;

  // Action codes carried on the input tuser.
  localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CANCEL   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

  // Status codes carried on the output tuser.
  localparam logic [STATUS_W-1:0] ST_ARMED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REARMED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_CANCEL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELOADED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd6;

  // One timer entry, as stored in the RAM.
  typedef struct packed {
    logic              repeat_flag;
    logic [TIME_W-1:0] reload_period;
    logic [TIME_W-1:0] remaining_time;
  } timer_entry_t;

  localparam int ENTRY_W = $bits(timer_entry_t);

endpackage

// ===== sv/msts_ram.sv =====
// ----------------------------------------------------------------------------
// msts_ram: generic simple dual-port RAM
// One write port and one read port with a registered read; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module msts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/multi_slot_timer_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// multi_slot_timer_scheduler_core: table of software-style timers
// Arms, re-arms and cancels timer slots and walks the table on every tick,
// reporting each timer that fires.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as words on the s_ channel: s_tuser holds the action
// (schedule, cancel, tick) and s_tdata the slot, period, repeat flag and
// elapsed time. Results leave as words on the m_ channel: m_tdata holds the
// slot, m_tuser the status, and m_tlast marks the final result of a command.
// A schedule or cancel command gives a single result, which is in the output
// register in the next cycle. A tick walks the timer RAM one slot per cycle
// while the walk is not stalled: reads for slots 0 to SLOTS-1 are issued back
// to back after the tick is taken, and each slot is updated and written back
// from its registered read data. The walk state then sees the walk drained and
// the flush state loads the final result into the output register. The single
// read port of the timer RAM sets the length of the walk.
// Firing results are held one deep in a pending register so that the last one
// can carry m_tlast; a tick with no firing reports one idle result.
// When the receiver stalls, the walk freezes on a firing slot that would need
// the busy output register; s_tready is low for the whole tick and whenever
// the output register holds a word that has not been taken.
// Reset clears all active marks and the control state; the RAM contents are
// left as they are and read data is only used for slots armed since reset.
// ----------------------------------------------------------------------------
module multi_slot_timer_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0 up: slot[3:0], period_us[30:0], repeat_req,
  // elapsed_us[19:0]
  input  logic [55:0] s_tdata,
  // s_tuser: action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0 up: slot_out[3:0], four zero bits
  output logic [7:0]  m_tdata,
  // m_tuser: status[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Unpacked input fields.
  logic [msts_pkg::ACTION_W-1:0]  in_action;
  logic [msts_pkg::SLOT_W-1:0]    in_slot;
  logic [msts_pkg::TIME_W-1:0]    in_period;
  logic                           in_repeat;
  logic [msts_pkg::ELAPSED_W-1:0] in_elapsed;

  assign in_action  = s_tuser;
  assign in_slot    = s_tdata[3:0];
  assign in_period  = s_tdata[34:4];
  assign in_repeat  = s_tdata[35];
  assign in_elapsed = s_tdata[55:36];

  // Active marks live in flip-flops so that reset clears them at once.
  logic [msts_pkg::SLOTS-1:0] active;

  // Output register.
  logic                          out_valid;
  logic [msts_pkg::SLOT_W-1:0]   out_slot;
  logic [msts_pkg::STATUS_W-1:0] out_status;
  logic                          out_last;
  logic                          out_free;

  // Tick walk: read counter, slot in process, pending firing result.
  logic [msts_pkg::CNT_W-1:0]     rd_cnt;
  logic                           p_valid;
  logic [msts_pkg::IDX_W-1:0]     p_idx;
  logic [msts_pkg::ELAPSED_W-1:0] elapsed;
  logic                           pend_valid;
  logic [msts_pkg::SLOT_W-1:0]    pend_slot;
  logic [msts_pkg::STATUS_W-1:0]  pend_status;

  logic accept;
  logic slot_in_range;
  logic [msts_pkg::IDX_W-1:0] slot_idx;
  logic sched_ok;
  logic cancel_cmd;
  logic issue;
  logic walk_done;

  msts_pkg::timer_entry_t rd_entry;
  msts_pkg::timer_entry_t wr_entry;
  logic [msts_pkg::ENTRY_W-1:0] ram_rdata;
  logic                         ram_we;
  logic [msts_pkg::IDX_W-1:0]   ram_waddr;

  logic [msts_pkg::TIME_W-1:0] elapsed_ext;
  logic p_active;
  logic p_fire;
  logic p_dec;
  logic need_push;
  logic stall;
  logic load_cmd;
  logic load_push;
  logic load_final;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign slot_in_range = 32'(in_slot) < msts_pkg::SLOTS;
  assign slot_idx      = msts_pkg::IDX_W'(in_slot);
  assign sched_ok      = accept && (in_action == msts_pkg::ACT_SCHEDULE) && slot_in_range;
  assign cancel_cmd    = accept && (in_action == msts_pkg::ACT_CANCEL);

  // Walk control. A read is issued each cycle, unless the walk is stalled, until
  // every slot is read; each slot is updated from its registered read data, so
  // the write address stays one behind the read address; no forwarding is needed.
  assign issue     = (state == S_WALK) && !stall
                     && (rd_cnt != msts_pkg::CNT_W'(msts_pkg::SLOTS));
  assign walk_done = (state == S_WALK) && !p_valid
                     && (rd_cnt == msts_pkg::CNT_W'(msts_pkg::SLOTS));

  assign rd_entry    = msts_pkg::timer_entry_t'(ram_rdata);
  assign elapsed_ext = msts_pkg::TIME_W'(elapsed);
  assign p_active    = p_valid && active[p_idx];
  // A timer fires when its remaining time does not exceed the elapsed time.
  assign p_fire      = p_active && !(rd_entry.remaining_time > elapsed_ext);
  assign p_dec       = p_active && (rd_entry.remaining_time > elapsed_ext);

  // A second firing pushes the pending result out; it waits for the output.
  assign need_push = p_fire && pend_valid;
  assign stall     = need_push && !out_free;

  assign load_cmd   = sched_ok || cancel_cmd;
  assign load_push  = need_push && out_free;
  assign load_final = (state == S_FLUSH) && out_free;

  // RAM write: schedule in idle, decrement or reload during the walk.
  always_comb begin
    wr_entry  = rd_entry;
    ram_we    = 1'b0;
    ram_waddr = p_idx;
    if (state == S_IDLE) begin
      ram_waddr               = slot_idx;
      ram_we                  = sched_ok;
      wr_entry.repeat_flag    = in_repeat;
      wr_entry.reload_period  = in_period;
      wr_entry.remaining_time = in_period;
    end else if (p_dec) begin
      ram_we                  = 1'b1;
      wr_entry.remaining_time = rd_entry.remaining_time - elapsed_ext;
    end else if (p_fire && rd_entry.repeat_flag && !stall) begin
      ram_we                  = 1'b1;
      wr_entry.remaining_time = rd_entry.reload_period;
    end
  end

  msts_ram #(
    .WIDTH (msts_pkg::ENTRY_W),
    .DEPTH (msts_pkg::SLOTS)
  ) u_timer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (rd_cnt[msts_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (in_action == msts_pkg::ACT_TICK)) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= '0;
      out_valid  <= 1'b0;
      p_valid    <= 1'b0;
      pend_valid <= 1'b0;
      rd_cnt     <= '0;
    end else begin
      state <= state_next;

      // Active marks.
      if (sched_ok) begin
        active[slot_idx] <= 1'b1;
      end else if (cancel_cmd && slot_in_range) begin
        active[slot_idx] <= 1'b0;
      end else if (p_fire && !rd_entry.repeat_flag && !stall) begin
        active[p_idx] <= 1'b0;
      end

      // Walk pipeline.
      if (accept && (in_action == msts_pkg::ACT_TICK)) begin
        rd_cnt  <= '0;
        p_valid <= 1'b0;
      end else if (!stall) begin
        p_valid <= issue;
        if (issue) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
      end

      // Pending firing result.
      if (p_fire && !stall) begin
        pend_valid <= 1'b1;
      end else if (load_final) begin
        pend_valid <= 1'b0;
      end

      // Output register.
      if (load_cmd || load_push || load_final) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && (in_action == msts_pkg::ACT_TICK)) begin
      elapsed <= in_elapsed;
    end
    if (!stall && issue) begin
      p_idx <= rd_cnt[msts_pkg::IDX_W-1:0];
    end
    if (p_fire && !stall) begin
      pend_slot   <= msts_pkg::SLOT_W'(p_idx);
      pend_status <= rd_entry.repeat_flag ? msts_pkg::ST_RELOADED : msts_pkg::ST_REMOVED;
    end
    priority if (load_cmd) begin
      out_slot <= in_slot;
      out_last <= 1'b1;
      if (sched_ok) begin
        out_status <= active[slot_idx] ? msts_pkg::ST_REARMED : msts_pkg::ST_ARMED;
      end else begin
        out_status <= (slot_in_range && active[slot_idx]) ? msts_pkg::ST_CANCELLED
                                                          : msts_pkg::ST_NO_CANCEL;
      end
    end else if (load_push) begin
      out_slot   <= pend_slot;
      out_status <= pend_status;
      out_last   <= 1'b0;
    end else if (load_final) begin
      out_last <= 1'b1;
      if (pend_valid) begin
        out_slot   <= pend_slot;
        out_status <= pend_status;
      end else begin
        out_slot   <= '0;
        out_status <= msts_pkg::ST_IDLE;
      end
    end else begin
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_slot};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  // A frozen walk must not touch the table.
  a_stall_no_write: assert property (@(posedge clk) disable iff (rst)
    stall |-> !ram_we)
    else $error("timer RAM written while the walk is stalled");

  // The read and write ports never meet on one entry.
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && issue) |-> (ram_waddr != rd_cnt[msts_pkg::IDX_W-1:0]))
    else $error("read and write of the same timer entry in one cycle");

  // No firing result is left behind once a tick has finished.
  a_pend_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending firing result left over in idle");

  // A slot is only in process during the walk.
  a_proc_in_walk: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == S_WALK))
    else $error("slot in process outside the walk");

  // The closing cycle of a tick always hands a word to the output.
  a_flush_delivers: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FLUSH) && out_free) |=> (m_tvalid && m_tlast))
    else $error("tick closed without a final result");

endmodule

// ===== tb/multi_slot_timer_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// multi_slot_timer_scheduler_core_tb: self-checking bench for the timer table
// Drives schedule, cancel, tick and unused action words through the input
// stream. A short table of directed commands runs first, followed by random
// traffic. Results are checked against a behavioral timer table kept here.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module multi_slot_timer_scheduler_core_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_CMDS   = 390;
  localparam int DIRECTED_ROWS = 22;

  // Action code 3 is not decoded by the block and must be dropped silently.
  localparam logic [msts_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [msts_pkg::TIME_W-1:0]    PERIOD_MAX  = 31'h7FFF_FFFF;
  localparam logic [msts_pkg::ELAPSED_W-1:0] ELAPSED_MAX = 20'hF_FFFF;

  // How a command's results are obtained: from the timer table model, typed
  // in as a single word, or none at all.
  typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} check_kind_e;

  typedef struct packed {
    logic [msts_pkg::ACTION_W-1:0]  action;
    logic [msts_pkg::SLOT_W-1:0]    slot;
    logic [msts_pkg::TIME_W-1:0]    period;
    logic                           rep;
    logic [msts_pkg::ELAPSED_W-1:0] elapsed;
    check_kind_e                    how;
    logic [msts_pkg::SLOT_W-1:0]    ev_slot;
    logic [msts_pkg::STATUS_W-1:0]  ev_status;
  } timer_cmd_t;

  typedef struct packed {
    logic [msts_pkg::SLOT_W-1:0]   slot;
    logic [msts_pkg::STATUS_W-1:0] status;
    logic                          last;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // Model of the timer table.
  logic                          slot_armed   [msts_pkg::SLOTS];
  logic [msts_pkg::TIME_W-1:0]   time_left    [msts_pkg::SLOTS];
  logic [msts_pkg::TIME_W-1:0]   reload_value [msts_pkg::SLOTS];
  logic                          repeats      [msts_pkg::SLOTS];

  timer_event_t step_events [$];
  timer_event_t pending_timer_events [$];
  timer_event_t seen_event;

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  // Directed commands. Single-word answers that follow at a glance from the
  // table's contents are typed in; ticks with firings go through the model.
  timer_cmd_t directed_plan [DIRECTED_ROWS] = '{
    // Nothing is armed after reset: a cancel has nothing to clear.
    '{msts_pkg::ACT_CANCEL, 4'd0, 31'd0, 1'b0, 20'd0,
      CHK_ONE, 4'd0, msts_pkg::ST_NO_CANCEL},
    // Tick over an empty table gives the idle word.
    '{msts_pkg::ACT_TICK, 4'd0, 31'd0, 1'b0, 20'd0,
      CHK_ONE, 4'd0, msts_pkg::ST_IDLE},
    // A zero period that repeats fires on every tick.
    '{msts_pkg::ACT_SCHEDULE, 4'd0, 31'd0, 1'b1, 20'd0,
      CHK_ONE, 4'd0, msts_pkg::ST_ARMED},
    '{msts_pkg::ACT_SCHEDULE, 4'd15, PERIOD_MAX, 1'b0, 20'd0,
      CHK_ONE, 4'd15, msts_pkg::ST_ARMED},
    '{msts_pkg::ACT_SCHEDULE, 4'd15, PERIOD_MAX, 1'b1, 20'd0,
      CHK_ONE, 4'd15, msts_pkg::ST_REARMED},
    '{msts_pkg::ACT_TICK, 4'd0, 31'd0, 1'b0, 20'd0,
      CHK_MODEL, 4'd0, msts_pkg::ST_IDLE},
    '{msts_pkg::ACT_TICK, 4'd0, 31'd0, 1'b0, ELAPSED_MAX,
      CHK_MODEL, 4'd0, msts_pkg::ST_IDLE},
    // Remaining time equal to the elapsed time fires.
    '{msts_pkg::ACT_SCHEDULE, 4'd5, 31'd100, 1'b0, 20'd0,
      CHK_ONE, 4'd5, msts_pkg::ST_ARMED},
    '{msts_pkg::ACT_TICK, 4'd0, 31'd0, 1'b0, 20'd100,
      CHK_MODEL, 4'd0, msts_pkg::ST_IDLE},
    '{msts_pkg::ACT_CANCEL, 4'd5, 31'd0, 1'b0, 20'd0,
      CHK_ONE, 4'd5, msts_pkg::ST_NO_CANCEL},
    '{msts_pkg::ACT_CANCEL, 4'd0, 31'd0, 1'b0, 20'd0,
      CHK_ONE, 4'd0, msts_pkg::ST_CANCELLED},
    '{ACT_UNUSED, 4'd2, 31'd55, 1'b1, 20'd9,
      CHK_NONE, 4'd0, msts_pkg::ST_IDLE},
    '{msts_pkg::ACT_SCHEDULE, 4'd7, 31'd1, 1'b1, 20'd0,
      CHK_ONE, 4'd7, msts_pkg::ST_ARMED},
    '{msts_pkg::ACT_SCHEDULE, 4'd8, 31'd2, 1'b0, 20'd0,
      CHK_ONE, 4'd8, msts_pkg::ST_ARMED},
    '{msts_pkg::ACT_TICK, 4'd0, 31'd0, 1'b0, 20'd1,
      CHK_MODEL, 4'd0, msts_pkg::ST_IDLE},
    '{msts_pkg::ACT_TICK, 4'd0, 31'd0, 1'b0, 20'd1,
      CHK_MODEL, 4'd0, msts_pkg::ST_IDLE},
    // A one-shot zero period fires once and is removed.
    '{msts_pkg::ACT_SCHEDULE, 4'd3, 31'd0, 1'b0, 20'd0,
      CHK_ONE, 4'd3, msts_pkg::ST_ARMED},
    '{msts_pkg::ACT_TICK, 4'd0, 31'd0, 1'b0, 20'd0,
      CHK_MODEL, 4'd0, msts_pkg::ST_IDLE},
    '{msts_pkg::ACT_CANCEL, 4'd15, 31'd0, 1'b0, 20'd0,
      CHK_ONE, 4'd15, msts_pkg::ST_CANCELLED},
    '{msts_pkg::ACT_CANCEL, 4'd7, 31'd0, 1'b0, 20'd0,
      CHK_ONE, 4'd7, msts_pkg::ST_CANCELLED},
    // Everything has been cleared, so the largest tick is idle again.
    '{msts_pkg::ACT_TICK, 4'd9, PERIOD_MAX, 1'b1, ELAPSED_MAX,
      CHK_ONE, 4'd0, msts_pkg::ST_IDLE},
    '{ACT_UNUSED, 4'd15, PERIOD_MAX, 1'b1, ELAPSED_MAX,
      CHK_NONE, 4'd0, msts_pkg::ST_IDLE}
  };

  multi_slot_timer_scheduler_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  task flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Applies one command to the modeled table and leaves the words it causes
  // in step_events, with the last flag on the final one.
  function void apply_timer_command(input timer_cmd_t c);
    step_events.delete();
    case (c.action)
      msts_pkg::ACT_SCHEDULE: begin
        if (c.slot < msts_pkg::SLOTS) begin
          step_events.push_back({c.slot,
                                 slot_armed[c.slot] ? msts_pkg::ST_REARMED
                                                    : msts_pkg::ST_ARMED,
                                 1'b0});
          slot_armed[c.slot]   = 1'b1;
          time_left[c.slot]    = c.period;
          reload_value[c.slot] = c.period;
          repeats[c.slot]      = c.rep;
        end
      end
      msts_pkg::ACT_CANCEL: begin
        if (c.slot < msts_pkg::SLOTS && slot_armed[c.slot]) begin
          slot_armed[c.slot] = 1'b0;
          step_events.push_back({c.slot, msts_pkg::ST_CANCELLED, 1'b0});
        end else begin
          step_events.push_back({c.slot, msts_pkg::ST_NO_CANCEL, 1'b0});
        end
      end
      msts_pkg::ACT_TICK: begin
        for (int i = 0; i < msts_pkg::SLOTS; i++) begin
          if (slot_armed[i]) begin
            if (time_left[i] > msts_pkg::TIME_W'(c.elapsed)) begin
              time_left[i] = time_left[i] - msts_pkg::TIME_W'(c.elapsed);
            end else if (step_events.size() < 16) begin
              if (repeats[i]) begin
                time_left[i] = reload_value[i];
                step_events.push_back({msts_pkg::SLOT_W'(i), msts_pkg::ST_RELOADED, 1'b0});
              end else begin
                slot_armed[i] = 1'b0;
                time_left[i]  = '0;
                step_events.push_back({msts_pkg::SLOT_W'(i), msts_pkg::ST_REMOVED, 1'b0});
              end
            end
          end
        end
        if (step_events.size() == 0) begin
          step_events.push_back({msts_pkg::SLOT_W'(0), msts_pkg::ST_IDLE, 1'b0});
        end
      end
      default: ;
    endcase
    if (step_events.size() != 0) begin
      step_events[step_events.size() - 1].last = 1'b1;
    end
  endfunction

  // Presents one command word, waits for its handshake, records what it must
  // produce and then applies the sender's burst and gap pacing.
  task send_command(input timer_cmd_t c);
    int gap;
    s_tuser  <= c.action;
    s_tdata  <= {c.elapsed, c.rep, c.period, c.slot};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    apply_timer_command(c);
    case (c.how)
      CHK_MODEL: foreach (step_events[k]) pending_timer_events.push_back(step_events[k]);
      CHK_ONE:   pending_timer_events.push_back({c.ev_slot, c.ev_status, 1'b1});
      default: ;
    endcase
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      // Now and then a long burst gives a stretch with no sender gaps.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Random command with noise in the fields its action does not use. Most
  // periods are short so that ticks fire often; a few use all 31 bits.
  function timer_cmd_t random_command();
    timer_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.action  = (pick < 40) ? msts_pkg::ACT_SCHEDULE : (pick < 60) ? msts_pkg::ACT_CANCEL :
                (pick < 95) ? msts_pkg::ACT_TICK : ACT_UNUSED;
    c.slot    = msts_pkg::SLOT_W'($urandom_range(0, 15));
    c.rep     = 1'($urandom_range(0, 1));
    c.period  = msts_pkg::TIME_W'($urandom);
    c.elapsed = msts_pkg::ELAPSED_W'($urandom);
    if (c.action == msts_pkg::ACT_SCHEDULE) begin
      pick = $urandom_range(0, 9);
      if (pick == 1) c.period = '0;
      else if (pick > 1) c.period = msts_pkg::TIME_W'($urandom_range(0, 4000));
    end else if (c.action == msts_pkg::ACT_TICK) begin
      pick = $urandom_range(0, 9);
      if (pick == 1) c.elapsed = '0;
      else if (pick > 1) c.elapsed = msts_pkg::ELAPSED_W'($urandom_range(0, 1500));
    end
    c.how       = (c.action == ACT_UNUSED) ? CHK_NONE : CHK_MODEL;
    c.ev_slot   = '0;
    c.ev_status = msts_pkg::ST_IDLE;
    return c;
  endfunction

  // Receiver stall pattern: phases of random length, each with its own mode.
  always @(posedge clk) begin
    stall_tick++;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((stall_tick % 16) < 4);
    endcase
  end

  // Each word taken from the output is checked against the oldest one due.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_timer_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected word slot %0d status %0d last %0b",
                                m_tdata[3:0], m_tuser, m_tlast));
      end else begin
        seen_event = pending_timer_events.pop_front();
        if (m_tdata[3:0] !== seen_event.slot) begin
          flag_mismatch($sformatf("slot %0d, wanted %0d", m_tdata[3:0], seen_event.slot));
        end
        if (m_tuser !== seen_event.status) begin
          flag_mismatch($sformatf("status %0d, wanted %0d on slot %0d",
                                  m_tuser, seen_event.status, seen_event.slot));
        end
        if (m_tlast !== seen_event.last) begin
          flag_mismatch($sformatf("last %0b, wanted %0b on slot %0d",
                                  m_tlast, seen_event.last, seen_event.slot));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int sent;
    timer_cmd_t c;
    for (int i = 0; i < msts_pkg::SLOTS; i++) begin
      slot_armed[i]   = 1'b0;
      time_left[i]    = '0;
      reload_value[i] = '0;
      repeats[i]      = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_command(directed_plan[r]);
    end

    // Dropped action codes do not count toward the random total.
    sent = 0;
    while (sent < RANDOM_CMDS) begin
      c = random_command();
      send_command(c);
      if (c.action != ACT_UNUSED) sent++;
    end
    s_tvalid <= 1'b0;

    while (pending_timer_events.size() != 0) @(posedge clk);
    repeat (msts_pkg::SLOTS + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
